// ===== design/rpub_pkg.sv =====
// ----------------------------------------------------------------------------
// rpub_pkg
// Shared types and constants for the packed raw10 unpack and Bayer crop core.
// ----------------------------------------------------------------------------
package rpub_pkg;

    localparam int DIM_W       = 14;
    localparam int LINE_W      = 16;
    localparam int PIX_W       = 8;
    localparam int PHASE_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int GROUP_BYTES = 5;
    localparam int PIXEL_BYTES = 4;
    localparam int MAX_DIM     = 16383;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_LINE_BYTES   = 2'd2,
        REG_BAYER_ORDER  = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        BAYER_RGGB = 2'd0,
        BAYER_GRBG = 2'd1,
        BAYER_GBRG = 2'd2,
        BAYER_BGGR = 2'd3
    } t_bayer;

    typedef struct packed {
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [LINE_W-1:0] line_bytes;
        t_bayer            bayer_order;
    } t_cfg;

    typedef struct packed {
        logic             keep;
        logic [PIX_W-1:0] pixel_value;
        logic             end_of_line;
        logic             end_of_frame;
    } t_result;

endpackage

// ===== design/rpub_if.sv =====
// ----------------------------------------------------------------------------
// rpub_if
// Valid/ready channel interfaces for input bytes, output pixels and setup.
// ----------------------------------------------------------------------------
interface rpub_byte_if;
    logic                        valid;
    logic                        ready;
    logic [rpub_pkg::PIX_W-1:0]  raw_byte;

    modport source (output valid, output raw_byte, input ready);
    modport sink   (input valid, input raw_byte, output ready);
endinterface

interface rpub_pix_if;
    logic                        valid;
    logic                        ready;
    logic [rpub_pkg::PIX_W-1:0]  pixel_value;
    logic                        end_of_line;
    logic                        end_of_frame;

    modport source (output valid, output pixel_value, output end_of_line,
                    output end_of_frame, input ready);
    modport sink   (input valid, input pixel_value, input end_of_line,
                    input end_of_frame, output ready);
endinterface

interface rpub_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rpub_pkg::CFG_IDX_W-1:0]   index;
    logic [rpub_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/raw10_packed_unpack_bayer_crop_core.sv =====
// ----------------------------------------------------------------------------
// raw10_packed_unpack_bayer_crop_core
// Packed raw10 byte stream to cropped 8-bit GRBG pixel stream.
// ----------------------------------------------------------------------------
// The sensor byte stream enters on i_byte, one packed byte per transfer. In
// each five-byte group the first four bytes are pixel upper bits and the
// fifth is dropped, as are pixels beyond the image width and line padding.
// Rows and columns are cropped by Bayer order so that o_pix carries GRBG
// pixels with end-of-line and end-of-frame marks.
// Setup registers are written on i_cfg, which is always ready; write them
// only while no transfer is in flight.
// One byte is taken per cycle. A kept pixel appears on o_pix in the cycle
// after its byte transfer, from a single output register. While that
// register holds a pixel the receiver has not taken, i_byte is not ready;
// when the receiver takes it in the same cycle, the next byte is accepted.
// Reset clears the position counters and the output valid and restores the
// default setup of 640 by 480 pixels, 800 bytes per line, BGGR order.
// ----------------------------------------------------------------------------
module raw10_packed_unpack_bayer_crop_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpub_cfg_if.sink    i_cfg,
    rpub_byte_if.sink   i_byte,
    rpub_pix_if.source  o_pix
);

    rpub_pkg::t_cfg     w_cfg;
    rpub_pkg::t_result  w_result;
    logic               w_in_ready;
    logic               w_accept;

    assign i_byte.ready = w_in_ready;
    assign w_accept     = i_byte.valid && w_in_ready;

    rpub_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    rpub_tracker u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_raw_byte (i_byte.raw_byte),
        .i_cfg      (w_cfg),
        .o_result   (w_result)
    );

    rpub_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_result   (w_result),
        .o_in_ready (w_in_ready),
        .o_pix      (o_pix)
    );

endmodule

// ===== design/rpub_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rpub_cfg_regs
// Configuration register bank written through the setup channel.
// ----------------------------------------------------------------------------
module rpub_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rpub_cfg_if.sink        i_cfg,
    output rpub_pkg::t_cfg  o_cfg
);

    rpub_pkg::t_cfg r_cfg;
    rpub_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (rpub_pkg::t_reg_idx'(i_cfg.index))
                rpub_pkg::REG_IMAGE_WIDTH: begin
                    n_cfg.image_width = i_cfg.data[rpub_pkg::DIM_W-1:0];
                end
                rpub_pkg::REG_IMAGE_HEIGHT: begin
                    n_cfg.image_height = i_cfg.data[rpub_pkg::DIM_W-1:0];
                end
                rpub_pkg::REG_LINE_BYTES: begin
                    n_cfg.line_bytes = i_cfg.data[rpub_pkg::LINE_W-1:0];
                end
                rpub_pkg::REG_BAYER_ORDER: begin
                    n_cfg.bayer_order = rpub_pkg::t_bayer'(i_cfg.data[1:0]);
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= rpub_pkg::DIM_W'(640);
            r_cfg.image_height <= rpub_pkg::DIM_W'(480);
            r_cfg.line_bytes   <= rpub_pkg::LINE_W'(800);
            r_cfg.bayer_order  <= rpub_pkg::BAYER_BGGR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/rpub_tracker.sv =====
// ----------------------------------------------------------------------------
// rpub_tracker
// Byte, group, pixel and row position counters with the keep/crop decision.
// ----------------------------------------------------------------------------
module rpub_tracker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [rpub_pkg::PIX_W-1:0]  i_raw_byte,
    input  rpub_pkg::t_cfg              i_cfg,
    output rpub_pkg::t_result           o_result
);

    localparam int DW = rpub_pkg::DIM_W;
    localparam int LW = rpub_pkg::LINE_W;
    localparam int PW = rpub_pkg::PHASE_W;

    logic [PW-1:0] r_phase;
    logic [PW-1:0] n_phase;
    logic [LW-1:0] r_byte_pos;
    logic [LW-1:0] n_byte_pos;
    logic [DW-1:0] r_pix_pos;
    logic [DW-1:0] n_pix_pos;
    logic [DW-1:0] r_row_pos;
    logic [DW-1:0] n_row_pos;

    logic          w_crop_cols;
    logic          w_crop_rows;
    logic          w_pixel_byte;
    logic [DW:0]   w_col_end;
    logic [DW:0]   w_row_end;
    logic          w_col_ok;
    logic          w_row_ok;
    logic          w_eol;
    logic          w_last_row;
    logic          w_line_end;
    logic          w_row_wrap;

    assign w_crop_cols = (i_cfg.bayer_order == rpub_pkg::BAYER_RGGB) ||
                         (i_cfg.bayer_order == rpub_pkg::BAYER_GBRG);
    assign w_crop_rows = (i_cfg.bayer_order == rpub_pkg::BAYER_GBRG) ||
                         (i_cfg.bayer_order == rpub_pkg::BAYER_BGGR);

    assign w_pixel_byte = r_phase < PW'(rpub_pkg::PIXEL_BYTES);

    // Position plus one plus the crop margin, compared against the size.
    assign w_col_end  = {1'b0, r_pix_pos} + (DW+1)'(1) + (DW+1)'(w_crop_cols);
    assign w_row_end  = {1'b0, r_row_pos} + (DW+1)'(1) + (DW+1)'(w_crop_rows);
    assign w_col_ok   = (r_pix_pos >= DW'(w_crop_cols)) &&
                        (w_col_end <= {1'b0, i_cfg.image_width});
    assign w_row_ok   = (r_row_pos >= DW'(w_crop_rows)) &&
                        (w_row_end <= {1'b0, i_cfg.image_height});
    assign w_eol      = w_col_end == {1'b0, i_cfg.image_width};
    assign w_last_row = w_row_end == {1'b0, i_cfg.image_height};

    assign w_line_end = ({1'b0, r_byte_pos} + (LW+1)'(1)) >= {1'b0, i_cfg.line_bytes};
    assign w_row_wrap = ({1'b0, r_row_pos} + (DW+1)'(1)) >= {1'b0, i_cfg.image_height};

    always_comb begin
        o_result.keep         = w_pixel_byte && w_col_ok && w_row_ok;
        o_result.pixel_value  = i_raw_byte;
        o_result.end_of_line  = w_eol;
        o_result.end_of_frame = w_eol && w_last_row;
    end

    always_comb begin
        n_phase    = r_phase;
        n_byte_pos = r_byte_pos;
        n_pix_pos  = r_pix_pos;
        n_row_pos  = r_row_pos;
        if (i_accept) begin
            if (w_pixel_byte && (r_pix_pos != DW'(rpub_pkg::MAX_DIM))) begin
                n_pix_pos = r_pix_pos + DW'(1);
            end
            if (r_phase >= PW'(rpub_pkg::GROUP_BYTES - 1)) begin
                n_phase = '0;
            end else begin
                n_phase = r_phase + PW'(1);
            end
            if (w_line_end) begin
                n_byte_pos = '0;
                n_phase    = '0;
                n_pix_pos  = '0;
                n_row_pos  = w_row_wrap ? '0 : r_row_pos + DW'(1);
            end else begin
                n_byte_pos = r_byte_pos + LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_byte_pos <= '0;
            r_pix_pos  <= '0;
            r_row_pos  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_byte_pos <= n_byte_pos;
            r_pix_pos  <= n_pix_pos;
            r_row_pos  <= n_row_pos;
        end
    end

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PW'(rpub_pkg::GROUP_BYTES - 1))
        else $error("group phase out of range");

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && w_line_end |=> (r_byte_pos == '0) && (r_row_pos <= $past(r_row_pos)
        + DW'(1)))
        else $error("line end did not restart the byte position");

    a_line_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_pos == '0) |-> (r_pix_pos == '0) && (r_phase == '0))
        else $error("line start with stale pixel or group position");

endmodule

// ===== design/rpub_out_stage.sv =====
// ----------------------------------------------------------------------------
// rpub_out_stage
// Output register for kept pixels, decoupling the receiver from the input.
// ----------------------------------------------------------------------------
module rpub_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  rpub_pkg::t_result  i_result,
    output logic               o_in_ready,
    rpub_pix_if.source         o_pix
);

    logic                        r_valid;
    logic                        n_valid;
    logic [rpub_pkg::PIX_W-1:0]  r_pixel;
    logic                        r_eol;
    logic                        r_eof;
    logic                        w_load;

    assign o_in_ready = !r_valid || o_pix.ready;
    assign w_load     = i_accept && i_result.keep;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (o_pix.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pixel <= i_result.pixel_value;
            r_eol   <= i_result.end_of_line;
            r_eof   <= i_result.end_of_frame;
        end
    end

    assign o_pix.valid        = r_valid;
    assign o_pix.pixel_value  = r_pixel;
    assign o_pix.end_of_line  = r_eol;
    assign o_pix.end_of_frame = r_eof;

endmodule

// ===== tb/rpub_crop_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpub_crop_checker
// Watches the setup, byte and pixel channels of the raw10 unpack and crop
// core. It keeps its own copy of the setup registers and line positions,
// predicts the pixel that each accepted byte yields, and compares every pixel
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rpub_crop_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rpub_cfg_if   i_cfg,
    rpub_byte_if  i_byte,
    rpub_pix_if   i_pix,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic [rpub_pkg::PIX_W-1:0] value;
        logic                       eol;
        logic                       eof;
    } t_marked_pixel;

    logic [rpub_pkg::DIM_W-1:0]  width_q;
    logic [rpub_pkg::DIM_W-1:0]  height_q;
    logic [rpub_pkg::LINE_W-1:0] line_bytes_q;
    rpub_pkg::t_bayer            order_q;

    int group_slot;
    int byte_pos;
    int pix_pos;
    int row_pos;
    int fails;

    t_marked_pixel kept_pixels_q[$];

    task automatic unpack_crop_byte(input logic [rpub_pkg::PIX_W-1:0] value);
        int            w;
        int            h;
        int            first_col;
        int            last_col;
        int            first_row;
        int            last_row;
        bit            crop_cols;
        bit            crop_rows;
        t_marked_pixel pix;
        w = int'(width_q);
        h = int'(height_q);
        crop_cols = (order_q == rpub_pkg::BAYER_RGGB) || (order_q == rpub_pkg::BAYER_GBRG);
        crop_rows = (order_q == rpub_pkg::BAYER_GBRG) || (order_q == rpub_pkg::BAYER_BGGR);
        first_col = crop_cols ? 1 : 0;
        last_col  = w - 1 - (crop_cols ? 1 : 0);
        first_row = crop_rows ? 1 : 0;
        last_row  = h - 1 - (crop_rows ? 1 : 0);
        if (group_slot < rpub_pkg::PIXEL_BYTES) begin
            if (pix_pos >= first_col && pix_pos <= last_col &&
                row_pos >= first_row && row_pos <= last_row) begin
                pix.value = value;
                pix.eol   = (pix_pos == last_col);
                pix.eof   = (pix_pos == last_col) && (row_pos == last_row);
                kept_pixels_q.push_back(pix);
            end
            if (pix_pos < rpub_pkg::MAX_DIM) begin
                pix_pos++;
            end
        end
        group_slot = (group_slot + 1 >= rpub_pkg::GROUP_BYTES) ? 0 : group_slot + 1;
        if (byte_pos + 1 >= int'(line_bytes_q)) begin
            byte_pos   = 0;
            group_slot = 0;
            pix_pos    = 0;
            row_pos    = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            byte_pos++;
        end
    endtask

    always @(posedge i_clk) begin
        t_marked_pixel want;
        if (!i_rst_n) begin
            width_q      = 14'd640;
            height_q     = 14'd480;
            line_bytes_q = 16'd800;
            order_q      = rpub_pkg::BAYER_BGGR;
            group_slot   = 0;
            byte_pos     = 0;
            pix_pos      = 0;
            row_pos      = 0;
            kept_pixels_q.delete();
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                if (kept_pixels_q.size() == 0) begin
                    fails++;
                    $display("%0t: expected no pixel, got %02h eol %0b eof %0b",
                             $time, i_pix.pixel_value, i_pix.end_of_line,
                             i_pix.end_of_frame);
                end else begin
                    want = kept_pixels_q.pop_front();
                    if (want.value !== i_pix.pixel_value || want.eol !== i_pix.end_of_line ||
                        want.eof !== i_pix.end_of_frame) begin
                        fails++;
                        $display("%0t: expected %02h eol %0b eof %0b, got %02h eol %0b eof %0b",
                                 $time, want.value, want.eol, want.eof,
                                 i_pix.pixel_value, i_pix.end_of_line, i_pix.end_of_frame);
                    end
                end
            end
            if (i_byte.valid && i_byte.ready) begin
                unpack_crop_byte(i_byte.raw_byte);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    rpub_pkg::REG_IMAGE_WIDTH:  width_q = i_cfg.data[rpub_pkg::DIM_W-1:0];
                    rpub_pkg::REG_IMAGE_HEIGHT: height_q = i_cfg.data[rpub_pkg::DIM_W-1:0];
                    rpub_pkg::REG_LINE_BYTES:   line_bytes_q = i_cfg.data[rpub_pkg::LINE_W-1:0];
                    rpub_pkg::REG_BAYER_ORDER:  order_q = rpub_pkg::t_bayer'(i_cfg.data[1:0]);
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= kept_pixels_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the raw10 unpack and Bayer crop core.
// Small frames in every Bayer order come first, then random formats: mostly
// well-formed frames, plus short lines, tiny and zero sizes and the largest
// register values. Both byte sender and pixel receiver idle at random.
// Setup changes only while no transfer is in flight; before each format the
// line and row positions are brought back to zero.
// ----------------------------------------------------------------------------
module tb;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_pixels;
    int   items_sent;

    rpub_cfg_if  cfg_ch ();
    rpub_byte_if byte_ch ();
    rpub_pix_if  pix_ch ();

    raw10_packed_unpack_bayer_crop_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_byte  (byte_ch),
        .o_pix   (pix_ch)
    );

    rpub_crop_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_ch),
        .i_byte       (byte_ch),
        .i_pix        (pix_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_pixels)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int run;
        int stall;
        pix_ch.ready = 1'b0;
        forever begin
            stall = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(8, 40);
            run   = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(20, 80);
            if (stall > 0) begin
                pix_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pix_ch.ready <= 1'b1;
            repeat (run) @(negedge i_clk);
        end
    end

    function automatic int pick_gap(input int level);
        int r;
        r = $urandom_range(0, 99);
        if (level == 0 || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return (level == 2) ? $urandom_range(6, 25) : $urandom_range(4, 10);
    endfunction

    function automatic int packed_bytes(input int w);
        return (w / rpub_pkg::PIXEL_BYTES) * rpub_pkg::GROUP_BYTES +
               (w % rpub_pkg::PIXEL_BYTES);
    endfunction

    task automatic send_byte(input logic [rpub_pkg::PIX_W-1:0] value, input int gap);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid    <= 1'b1;
        byte_ch.raw_byte <= value;
        do @(posedge i_clk); while (!byte_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_bytes(input int count, input int level, input bit marked);
        logic [rpub_pkg::PIX_W-1:0] value;
        for (int i = 0; i < count; i++) begin
            value = rpub_pkg::PIX_W'($urandom);
            if (marked && i == 0) begin
                value = 8'h00;
            end else if (marked && i == 1) begin
                value = 8'hFF;
            end
            send_byte(value, pick_gap(level));
        end
    endtask

    task automatic write_reg(input rpub_pkg::t_reg_idx idx,
                             input logic [rpub_pkg::CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        byte_ch.valid <= 1'b0;
        while (pending_pixels != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // A zero line length and zero height send the next byte to line and
    // row zero without producing a pixel.
    task automatic realign();
        write_reg(rpub_pkg::REG_LINE_BYTES, 16'd0);
        write_reg(rpub_pkg::REG_IMAGE_HEIGHT, 16'd0);
        cfg_ch.valid <= 1'b0;
        send_byte(rpub_pkg::PIX_W'($urandom), 0);
        wait_drain();
    endtask

    task automatic set_format(input int w, input int h, input int lb,
                              input rpub_pkg::t_bayer ord);
        write_reg(rpub_pkg::REG_IMAGE_WIDTH, {2'($urandom_range(0, 3)), 14'(w)});
        write_reg(rpub_pkg::REG_IMAGE_HEIGHT, {2'($urandom_range(0, 3)), 14'(h)});
        write_reg(rpub_pkg::REG_LINE_BYTES, 16'(lb));
        write_reg(rpub_pkg::REG_BAYER_ORDER, {14'($urandom), 2'(ord)});
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_frames(input int w, input int h, input int lb,
                              input rpub_pkg::t_bayer ord,
                              input int level, input bit marked);
        set_format(w, h, lb, ord);
        send_bytes(lb * h, level, marked);
        wait_drain();
    endtask

    initial begin
        int               phase_no;
        int               w;
        int               h;
        int               lb;
        int               count;
        int               level;
        int               kind;
        rpub_pkg::t_bayer ord;
        i_rst_n          = 1'b0;
        items_sent       = 0;
        byte_ch.valid    = 1'b0;
        byte_ch.raw_byte = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = rpub_pkg::REG_IMAGE_WIDTH;
        cfg_ch.data      = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The first row of the default frame is cropped, so nothing comes out.
        send_bytes(5, 1, 1);
        wait_drain();
        realign();

        run_frames(5, 2, 6, rpub_pkg::BAYER_GRBG, 1, 1);
        run_frames(3, 1, 3, rpub_pkg::BAYER_RGGB, 0, 1);
        run_frames(3, 3, 3, rpub_pkg::BAYER_GBRG, 2, 0);
        run_frames(2, 3, 2, rpub_pkg::BAYER_BGGR, 1, 1);

        phase_no = 0;
        while (items_sent < 1150) begin
            realign();
            level = $urandom_range(0, 2);
            ord   = rpub_pkg::t_bayer'($urandom_range(0, 3));
            w     = $urandom_range(2, 12);
            h     = $urandom_range(2, 5);
            lb    = packed_bytes(w) + $urandom_range(0, 3);
            count = lb * h * $urandom_range(1, 2);
            case (phase_no)
                1: begin
                    w     = rpub_pkg::MAX_DIM;
                    lb    = $urandom_range(4, 14);
                    count = $urandom_range(30, 60);
                end
                3: begin
                    h     = rpub_pkg::MAX_DIM;
                    count = lb * $urandom_range(3, 6);
                end
                5: begin
                    lb    = 65535;
                    count = $urandom_range(30, 60);
                end
                default: begin
                    kind = $urandom_range(0, 9);
                    if (kind == 7 || kind == 8) begin
                        w     = $urandom_range(5, 14);
                        lb    = $urandom_range(0, packed_bytes(w) - 1);
                        h     = $urandom_range(1, 4);
                        count = $urandom_range(10, 40);
                    end else if (kind == 9) begin
                        w     = $urandom_range(0, 3);
                        h     = $urandom_range(0, 3);
                        lb    = $urandom_range(0, 8);
                        count = $urandom_range(8, 30);
                    end
                end
            endcase
            set_format(w, h, lb, ord);
            send_bytes(count, level, 0);
            wait_drain();
            phase_no++;
        end

        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== raw10_packed_unpack_bayer_crop_core.f =====
design/rpub_pkg.sv
design/rpub_if.sv
design/rpub_cfg_regs.sv
design/rpub_tracker.sv
design/rpub_out_stage.sv
design/raw10_packed_unpack_bayer_crop_core.sv
tb/rpub_crop_checker.sv
tb/tb.sv
